### src/avr_pkg.sv
// avr_pkg: shared types, constants and the arctangent table for the axis rotation block.
// No dependencies; every other file in src refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package avr_pkg;

    // Vector component width (Q3.12)
    localparam int DATA_WIDTH   = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CMD_WIDTH    = 2;

    // CORDIC datapath: Q.30 with headroom for gain overshoot and atan sums
    localparam int FRAC_BITS    = 30;
    localparam int CS_W         = 33;
    localparam int COEF_W       = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam int STAGE_IDX_W  = 5;

    localparam logic signed [CS_W-1:0] GAIN_Q30 = 33'sd652032874;

    // Axis selector codes; any other code passes the vector through
    localparam logic [CMD_WIDTH-1:0] AXIS_X = 2'd0;
    localparam logic [CMD_WIDTH-1:0] AXIS_Y = 2'd1;
    localparam logic [CMD_WIDTH-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic        [CMD_WIDTH-1:0]   cmd;
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic signed [DATA_WIDTH-1:0]  in_x;
        logic signed [DATA_WIDTH-1:0]  in_y;
        logic signed [DATA_WIDTH-1:0]  in_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_x;
        logic signed [DATA_WIDTH-1:0] out_y;
        logic signed [DATA_WIDTH-1:0] out_z;
    } t_out;

    // Contents of one CORDIC cell: rotation state plus the vector riding along
    typedef struct packed {
        logic        [CMD_WIDTH-1:0]  cmd;
        logic                         flip;
        logic signed [CS_W-1:0]       x;
        logic signed [CS_W-1:0]       y;
        logic signed [CS_W-1:0]       z;
        logic signed [DATA_WIDTH-1:0] vx;
        logic signed [DATA_WIDTH-1:0] vy;
        logic signed [DATA_WIDTH-1:0] vz;
    } t_cell;

    // atan(2^-i), full turn = 2^32
    function automatic logic signed [CS_W-1:0] avr_atan(input logic [STAGE_IDX_W-1:0] idx);
        logic signed [CS_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/avr_cordic_cell.sv
// avr_cordic_cell: one CORDIC rotation stage with its own pipeline register.
// Depends on avr_pkg (t_cell, avr_atan).
`timescale 1ns / 1ps
`default_nettype none

module avr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  avr_pkg::t_cell      i_data,
    output logic                o_valid,
    output avr_pkg::t_cell      o_data
);

    logic                              r_valid;
    avr_pkg::t_cell                    r_data;
    avr_pkg::t_cell                    n_data;
    logic signed [avr_pkg::CS_W-1:0]   x_in;
    logic signed [avr_pkg::CS_W-1:0]   y_in;
    logic signed [avr_pkg::CS_W-1:0]   dx;
    logic signed [avr_pkg::CS_W-1:0]   dy;
    logic signed [avr_pkg::CS_W-1:0]   atan_c;

    always_comb begin
        x_in   = i_data.x;
        y_in   = i_data.y;
        dx     = y_in >>> STAGE;    // floor shift
        dy     = x_in >>> STAGE;
        atan_c = avr_pkg::avr_atan(avr_pkg::STAGE_IDX_W'(STAGE));
        n_data = i_data;
        if (!i_data.z[avr_pkg::CS_W-1]) begin
            n_data.x = x_in - dx;
            n_data.y = y_in + dy;
            n_data.z = i_data.z - atan_c;
        end else begin
            n_data.x = x_in + dx;
            n_data.y = y_in - dy;
            n_data.z = i_data.z + atan_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### src/avr_rotate.sv
// avr_rotate: multiplies the vector pair by cos/sin, rounds, saturates and holds the result.
// Two register stages (products, output). Depends on avr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avr_rotate (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  avr_pkg::t_cell      i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output avr_pkg::t_out       o_data
);

    localparam int DW  = avr_pkg::DATA_WIDTH;
    localparam int P_W = avr_pkg::COEF_W + DW;
    localparam int S_W = P_W + 1;
    localparam logic signed [S_W-1:0] RND    = S_W'(1) <<< (avr_pkg::FRAC_BITS - 1);
    localparam logic signed [S_W-1:0] SAT_HI = {{(S_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [S_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [DW-1:0] round_sat(input logic signed [S_W-1:0] acc);
        logic signed [S_W-1:0] sh;
        logic signed [DW-1:0]  r;
        sh = (acc + RND) >>> avr_pkg::FRAC_BITS;
        if (sh > SAT_HI) begin
            r = SAT_HI[DW-1:0];
        end else if (sh < SAT_LO) begin
            r = SAT_LO[DW-1:0];
        end else begin
            r = sh[DW-1:0];
        end
        return r;
    endfunction

    logic                                 en_p;
    logic                                 en_o;
    logic                                 r_p_valid;
    logic                                 r_o_valid;
    logic signed [avr_pkg::COEF_W-1:0]    c;
    logic signed [avr_pkg::COEF_W-1:0]    s;
    logic signed [DW-1:0]                 u;
    logic signed [DW-1:0]                 v;
    logic signed [P_W-1:0]                r_cu;
    logic signed [P_W-1:0]                r_sv;
    logic signed [P_W-1:0]                r_su;
    logic signed [P_W-1:0]                r_cv;
    logic [avr_pkg::CMD_WIDTH-1:0]        r_cmd;
    logic signed [DW-1:0]                 r_vx;
    logic signed [DW-1:0]                 r_vy;
    logic signed [DW-1:0]                 r_vz;
    logic signed [DW-1:0]                 u_rot;
    logic signed [DW-1:0]                 v_rot;
    avr_pkg::t_out                        n_out;
    avr_pkg::t_out                        r_out;

    assign en_o    = !r_o_valid || i_ready;
    assign en_p    = !r_p_valid || en_o;
    assign o_ready = en_p;

    // quadrant fold undone on cos/sin; magnitudes stay below 2^31
    always_comb begin
        c = i_data.flip ? avr_pkg::COEF_W'(-i_data.x) : avr_pkg::COEF_W'(i_data.x);
        s = i_data.flip ? avr_pkg::COEF_W'(-i_data.y) : avr_pkg::COEF_W'(i_data.y);
        case (i_data.cmd)
            avr_pkg::AXIS_X: begin
                u = i_data.vy;
                v = i_data.vz;
            end
            avr_pkg::AXIS_Y: begin
                u = i_data.vz;
                v = i_data.vx;
            end
            avr_pkg::AXIS_Z: begin
                u = i_data.vx;
                v = i_data.vy;
            end
            default: begin
                u = '0;
                v = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_cu  <= P_W'(c * u);
            r_sv  <= P_W'(s * v);
            r_su  <= P_W'(s * u);
            r_cv  <= P_W'(c * v);
            r_cmd <= i_data.cmd;
            r_vx  <= i_data.vx;
            r_vy  <= i_data.vy;
            r_vz  <= i_data.vz;
        end
    end

    // u' = c*u - s*v, v' = s*u + c*v
    always_comb begin
        u_rot = round_sat(S_W'(r_cu) - S_W'(r_sv));
        v_rot = round_sat(S_W'(r_su) + S_W'(r_cv));
        case (r_cmd)
            avr_pkg::AXIS_X: begin
                n_out = '{out_x: r_vx, out_y: u_rot, out_z: v_rot};
            end
            avr_pkg::AXIS_Y: begin
                n_out = '{out_x: v_rot, out_y: r_vy, out_z: u_rot};
            end
            avr_pkg::AXIS_Z: begin
                n_out = '{out_x: u_rot, out_y: v_rot, out_z: r_vz};
            end
            default: begin
                n_out = '{out_x: r_vx, out_y: r_vy, out_z: r_vz};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_p) begin
                r_p_valid <= i_valid;
            end
            if (en_o) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### src/axis_vector_rotation.sv
// axis_vector_rotation: rotates a Q3.12 3-vector about x, y or z by a binary angle.
// Pipeline: one CORDIC cell per stage, then a product register and the output register.
// Throughput: one vector per cycle while i_m_ready is held high.
// Reset (i_rst_n, synchronous, active low) clears all valid flags; the data registers are not reset.
// Depends on avr_pkg, avr_cordic_cell, avr_rotate.
`timescale 1ns / 1ps
`default_nettype none

module axis_vector_rotation #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input vector transaction
    input  wire                 i_s_valid,
    output logic                o_s_ready,
    input  avr_pkg::t_in        i_s_data,
    // rotated vector transaction
    output logic                o_m_valid,
    input  wire                 i_m_ready,
    output avr_pkg::t_out       o_m_data
);

    // Only the tabulated arctangents can be used.
    localparam int STAGES = (CORDIC_STAGES > avr_pkg::ATAN_ENTRIES) ?
                            avr_pkg::ATAN_ENTRIES : CORDIC_STAGES;

    // cell_valid[k]/cell_data[k] feed cell k; index STAGES is the chain's tail.
    logic               cell_valid [0:STAGES];
    avr_pkg::t_cell     cell_data  [0:STAGES];
    logic               cell_en    [0:STAGES];
    logic               rot_ready;

    // Quadrant fold: phase = angle << 16. Top phase bits 01 or 10 get a half turn
    // added (top bit inverted) and cos/sin negated at the end; the residual then
    // lies in [-2^30, 2^30) and is sign-extended into the z register.
    always_comb begin
        cell_valid[0]     = i_s_valid;
        cell_data[0].cmd  = i_s_data.cmd;
        cell_data[0].flip = i_s_data.angle[avr_pkg::ANGLE_WIDTH-1] ^
                            i_s_data.angle[avr_pkg::ANGLE_WIDTH-2];
        cell_data[0].x    = avr_pkg::GAIN_Q30;
        cell_data[0].y    = '0;
        cell_data[0].z    = avr_pkg::CS_W'($signed({
                                i_s_data.angle[avr_pkg::ANGLE_WIDTH-1] ^ cell_data[0].flip,
                                i_s_data.angle[avr_pkg::ANGLE_WIDTH-2:0],
                                {(32 - avr_pkg::ANGLE_WIDTH){1'b0}}}));
        cell_data[0].vx   = i_s_data.in_x;
        cell_data[0].vy   = i_s_data.in_y;
        cell_data[0].vz   = i_s_data.in_z;
    end

    // Per-stage flow control: a cell loads when it is empty or its successor
    // loads, so bubbles collapse while the output is stalled.
    assign cell_en[STAGES] = rot_ready;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_cell
            assign cell_en[k] = !cell_valid[k+1] || cell_en[k+1];

            avr_cordic_cell #(
                .STAGE   (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (cell_en[k]),
                .i_valid (cell_valid[k]),
                .i_data  (cell_data[k]),
                .o_valid (cell_valid[k+1]),
                .o_data  (cell_data[k+1])
            );
        end
    endgenerate

    assign o_s_ready = cell_en[0];

    // cos/sin times the two rotated components, round, saturate, output register
    avr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid[STAGES]),
        .o_ready (rot_ready),
        .i_data  (cell_data[STAGES]),
        .o_valid (o_m_valid),
        .i_ready (i_m_ready),
        .o_data  (o_m_data)
    );

endmodule

`default_nettype wire

### dv/avr_rotation_checker.sv
// avr_rotation_checker: watches both channels of axis_vector_rotation, predicts each
// rotated vector with its own CORDIC and compares results in order. Depends on avr_pkg.
`timescale 1ns / 1ps

module avr_rotation_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_valid,
    input  wire           i_s_ready,
    input  avr_pkg::t_in  i_s_data,
    input  wire           i_m_valid,
    input  wire           i_m_ready,
    input  avr_pkg::t_out i_m_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_checked
);

    localparam int STAGES_RUN = (CORDIC_STAGES > avr_pkg::ATAN_ENTRIES) ?
                                avr_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam longint HALF_LSB = 64'sd536870912;   // 2^29, rounding for Q.30

    avr_pkg::t_out expected_vectors[$];
    avr_pkg::t_out want;
    int            err_count = 0;
    int            checked_count = 0;

    // atan(2^-i), full turn = 2^32
    function automatic longint atan_step(input int idx);
        case (idx)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    // cos and sin in Q.30; quadrants 1 and 2 fold by a half turn and negate
    function automatic void cordic_sincos(input logic [avr_pkg::ANGLE_WIDTH-1:0] ang,
                                          output longint cos_q30, output longint sin_q30);
        logic [31:0] phase;
        logic        flip;
        longint      x, y, z, dx, dy;
        phase = {ang, 16'h0000};
        flip  = phase[31] ^ phase[30];
        if (flip) begin
            phase = phase + 32'h8000_0000;
        end
        z = longint'($signed(phase));
        x = longint'(avr_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < STAGES_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    function automatic longint mix_round(input longint c, input longint a,
                                         input longint s, input longint b);
        return (c * a + s * b + HALF_LSB) >>> avr_pkg::FRAC_BITS;
    endfunction

    function automatic logic signed [avr_pkg::DATA_WIDTH-1:0] clamp(input longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (avr_pkg::DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[avr_pkg::DATA_WIDTH-1:0];
        if (v < lo) return lo[avr_pkg::DATA_WIDTH-1:0];
        return v[avr_pkg::DATA_WIDTH-1:0];
    endfunction

    function automatic avr_pkg::t_out rotate_vector(input avr_pkg::t_in v);
        longint        vx, vy, vz, rx, ry, rz, c, s;
        avr_pkg::t_out r;
        vx = longint'($signed(v.in_x));
        vy = longint'($signed(v.in_y));
        vz = longint'($signed(v.in_z));
        rx = vx;
        ry = vy;
        rz = vz;
        cordic_sincos(v.angle, c, s);
        case (v.cmd)
            avr_pkg::AXIS_X: begin
                ry = mix_round(c, vy, -s, vz);
                rz = mix_round(s, vy, c, vz);
            end
            avr_pkg::AXIS_Y: begin
                rz = mix_round(c, vz, -s, vx);
                rx = mix_round(s, vz, c, vx);
            end
            avr_pkg::AXIS_Z: begin
                rx = mix_round(c, vx, -s, vy);
                ry = mix_round(s, vx, c, vy);
            end
            default: ;  // unused selector: vector passes through
        endcase
        r.out_x = clamp(rx);
        r.out_y = clamp(ry);
        r.out_z = clamp(rz);
        return r;
    endfunction

    task automatic compare_field(input string name,
                                 input logic signed [avr_pkg::DATA_WIDTH-1:0] exp_v,
                                 input logic signed [avr_pkg::DATA_WIDTH-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_valid && i_s_ready) begin
                expected_vectors.push_back(rotate_vector(i_s_data));
            end
            if (i_m_valid && i_m_ready) begin
                if (expected_vectors.size() == 0) begin
                    $error("result with no vector outstanding: x %0d y %0d z %0d",
                           i_m_data.out_x, i_m_data.out_y, i_m_data.out_z);
                    err_count++;
                end else begin
                    want = expected_vectors.pop_front();
                    compare_field("out_x", want.out_x, i_m_data.out_x);
                    compare_field("out_y", want.out_y, i_m_data.out_y);
                    compare_field("out_z", want.out_z, i_m_data.out_z);
                    checked_count++;
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_vectors.size();
        o_checked <= checked_count;
    end

endmodule

### dv/tb_top.sv
// tb_top: stimulus and verdict for axis_vector_rotation; directed corners, then random
// vectors under three idling profiles. Depends on avr_pkg, the block and avr_rotation_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int STAGES       = 16;
    localparam int LATENCY      = STAGES + 2;   // CORDIC cells plus the product and output registers
    localparam int RANDOM_BATCH = 500;          // random vectors per idling profile
    localparam int CYCLE_LIMIT  = 200000;       // far beyond the slowest legal run
    // selector outside the three axes: no rotation
    localparam logic [avr_pkg::CMD_WIDTH-1:0] AXIS_PASS = 2'd3;

    logic          clk     = 1'b0;
    logic          rst_n   = 1'b0;
    logic          s_valid = 1'b0;
    logic          m_ready = 1'b0;
    avr_pkg::t_in  s_data  = '0;
    logic          s_ready;
    logic          m_valid;
    avr_pkg::t_out m_data;

    int src_idle_pct = 20;
    int dst_idle_pct = 57;
    int cycle_count  = 0;
    int sent_count   = 0;
    int axis_seen[4] = '{0, 0, 0, 0};
    int err_total;
    int pending_total;
    int checked_total;

    initial begin
        forever #2 clk = ~clk;
    end

    axis_vector_rotation #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_s_valid(s_valid),
        .o_s_ready(s_ready),
        .i_s_data (s_data),
        .o_m_valid(m_valid),
        .i_m_ready(m_ready),
        .o_m_data (m_data)
    );

    avr_rotation_checker #(
        .CORDIC_STAGES(STAGES)
    ) u_rotation_chk (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_s_valid(s_valid),
        .i_s_ready(s_ready),
        .i_s_data (s_data),
        .i_m_valid(m_valid),
        .i_m_ready(m_ready),
        .i_m_data (m_data),
        .o_errors (err_total),
        .o_pending(pending_total),
        .o_checked(checked_total)
    );

    // Receiver backpressure: one fresh draw per cycle, so stalls land on every
    // pipeline phase. dst_idle_pct = 0 gives an always-ready sink.
    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Watchdog: the only other way out of the run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // One input transaction. Random idle cycles come first with valid low;
    // once valid goes high it holds, payload fixed, until the handshake edge.
    // Back-to-back items keep valid high with no low pulse in between.
    task automatic send_vector(input avr_pkg::t_in item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge clk); while (!s_ready);
        axis_seen[item.cmd]++;
        sent_count++;
    endtask

    function automatic avr_pkg::t_in make_vector(
        input logic [avr_pkg::CMD_WIDTH-1:0]          cmd,
        input logic signed [avr_pkg::ANGLE_WIDTH-1:0] angle,
        input logic signed [avr_pkg::DATA_WIDTH-1:0]  x,
        input logic signed [avr_pkg::DATA_WIDTH-1:0]  y,
        input logic signed [avr_pkg::DATA_WIDTH-1:0]  z
    );
        avr_pkg::t_in v;
        v.cmd   = cmd;
        v.angle = angle;
        v.in_x  = x;
        v.in_y  = y;
        v.in_z  = z;
        return v;
    endfunction

    // Mostly uniform; the rest pinned at or next to full scale to drive saturation, or near zero.
    function automatic logic [avr_pkg::DATA_WIDTH-1:0] random_component();
        case ($urandom_range(9))
            7:       return 16'h7FFF - 16'($urandom_range(3));
            8:       return 16'h8000 + 16'($urandom_range(3));
            9:       return 16'($urandom_range(8)) - 16'd4;   // near zero
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic avr_pkg::t_in random_vector();
        avr_pkg::t_in v;
        v.cmd = avr_pkg::CMD_WIDTH'($urandom_range(3));
        case ($urandom_range(9))
            // straddle a quadrant boundary, where the half-turn fold switches
            7:       v.angle = {2'($urandom_range(3)), 14'h0000} + 16'($urandom_range(6))
                               - 16'd3;
            8:       v.angle = 16'($urandom_range(64)) - 16'd32;   // tiny angles
            default: v.angle = 16'($urandom);
        endcase
        v.in_x = random_component();
        v.in_y = random_component();
        v.in_z = random_component();
        return v;
    endfunction

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: every axis at zero, quarter, half and minus quarter turn
        send_vector(make_vector(avr_pkg::AXIS_X, 16'sd0, 16'sd4096, -16'sd8192, 16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_X, 16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_X, -16'sd32768, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_X, -16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Y, 16'sd0, 16'sd4096, -16'sd8192, 16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Y, 16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Y, -16'sd32768, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Y, -16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Z, 16'sd0, 16'sd4096, -16'sd8192, 16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Z, 16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Z, -16'sd32768, 16'sd4096, -16'sd8192,
                                16'sd12288));
        send_vector(make_vector(avr_pkg::AXIS_Z, -16'sd16384, 16'sd4096, -16'sd8192,
                                16'sd12288));
        // 45 and -135 degrees on full-scale components: rotated magnitude overflows both ways
        send_vector(make_vector(avr_pkg::AXIS_Z, 16'sd8192, 16'sd32767, 16'sd32767, 16'sd0));
        send_vector(make_vector(avr_pkg::AXIS_Z, 16'sd8192, -16'sd32768, -16'sd32768,
                                16'sd0));
        send_vector(make_vector(avr_pkg::AXIS_X, 16'sd8192, 16'sd0, 16'sd32767, 16'sd32767));
        send_vector(make_vector(avr_pkg::AXIS_Y, -16'sd24576, -16'sd32768, 16'sd0,
                                -16'sd32768));
        // largest positive angle and the smallest negative step
        send_vector(make_vector(avr_pkg::AXIS_Y, 16'sd32767, 16'sd32767, -16'sd32768,
                                16'sd32767));
        send_vector(make_vector(avr_pkg::AXIS_X, -16'sd1, -16'sd32768, 16'sd32767,
                                -16'sd32768));
        // unused axis selector: vector must come back untouched
        send_vector(make_vector(AXIS_PASS, 16'sd12345, 16'sd32767, -16'sd32768, 16'sd1));
        send_vector(make_vector(AXIS_PASS, -16'sd32768, -16'sd1, 16'sd0, -16'sd32768));

        // Random part: sender-light/receiver-heavy, swapped, then no idling at all
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 20; dst_idle_pct = 57; end
                1: begin src_idle_pct = 57; dst_idle_pct = 20; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            repeat (RANDOM_BATCH) send_vector(random_vector());
        end
        s_valid <= 1'b0;

        // Drain, then wait on so that stray results can still show up
        do @(posedge clk); while (pending_total != 0);
        repeat (2 * LATENCY) @(posedge clk);

        $display("covered %0d vectors (about x %0d, y %0d, z %0d, pass-through %0d)",
                 sent_count, axis_seen[0], axis_seen[1], axis_seen[2], axis_seen[3]);
        $display("compared %0d rotated vectors against the predictor, %0d mismatches",
                 checked_total, err_total);
        if (err_total == 0 && pending_total == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
